/* hw/rtl/wtrm_pkg.sv */
// ----------------------------------------------------------------------------
// wtrm_pkg: windowed transfer rate meter - shared types and constants
// Word widths, item kinds, register indexes and reset values.
// ----------------------------------------------------------------------------
package wtrm_pkg;

    localparam int KIND_W     = 2;
    localparam int TIME_W     = 32;
    localparam int ADD_W      = 32;
    localparam int POS_W      = 48;
    localparam int MWIN_W     = 16;
    localparam int MSMP_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int IN_DATA_W  = 96;   // now_ms, add_bytes, add_actual
    localparam int OUT_DATA_W = 192;  // position, actual, speed, seconds left

    // shared divider: 58-bit dividend covers 48-bit bytes times 1000
    localparam int DIV_DW = 58;
    localparam int DIV_VW = 48;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_PROGRESS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_SIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILE_SIZE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHOLE_FILE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOW_SECS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES     = 3'd4;

    localparam logic [MWIN_W-1:0] RST_MIN_WINDOW_SECS = 16'd15;
    localparam logic [MSMP_W-1:0] RST_MIN_SAMPLES     = 7'd15;

    typedef enum logic [14:0] {
        ST_IDLE      = 15'h0001,
        ST_T_RD_OLD  = 15'h0002,
        ST_T_RD_NEW  = 15'h0004,
        ST_T_TRIM    = 15'h0008,
        ST_T_CHK     = 15'h0010,
        ST_T_SAME    = 15'h0020,
        ST_T_APPEND  = 15'h0040,
        ST_S_RD_OLD  = 15'h0080,
        ST_S_RD_NEW  = 15'h0100,
        ST_S_DIFF    = 15'h0200,
        ST_S_START   = 15'h0400,
        ST_S_DIV     = 15'h0800,
        ST_L_START   = 15'h1000,
        ST_L_DIV     = 15'h2000,
        ST_OUT       = 15'h4000
    } t_state;

endpackage

/* hw/rtl/wtrm_ram.sv */
// ----------------------------------------------------------------------------
// wtrm_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module wtrm_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/wtrm_div.sv */
// ----------------------------------------------------------------------------
// wtrm_div: iterative restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module wtrm_div #(
    parameter  int DW   = 58,
    parameter  int VW   = 48,
    localparam int CNTW = $clog2(DW + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quotient
);

    logic [DW-1:0]   r_q,   n_q;
    logic [VW-1:0]   r_rem, n_rem;
    logic [VW-1:0]   r_dvs;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [VW:0]     trial;
    logic [VW:0]     diff;
    logic            ge;

    always_comb begin
        trial = {r_rem, r_q[DW-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
        n_rem = ge ? diff[VW-1:0] : trial[VW-1:0];
        n_q   = {r_q[DW-2:0], ge};
        n_cnt = r_cnt - CNTW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNTW'(DW);
        end else if (r_cnt != '0) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_q;

endmodule

/* hw/rtl/windowed_transfer_rate_meter.sv */
// Progress, clear and unused-kind words run one divide (seconds left); a tick runs ring
// access plus at most two divides. A divide is skipped at zero speed or a negative
// remainder. One word at a time; the shared restoring divider sets the pace. Result
// register lets the next word in while a result waits.
// Synchronous active-low reset.
// ----------------------------------------------------------------------------
// windowed_transfer_rate_meter: sliding-window throughput meter
// Tracks position and actual byte counts, keeps a ring of (time, position)
// samples taken on ticks, and reports average speed and seconds left after
// every word.
// ----------------------------------------------------------------------------
module windowed_transfer_rate_meter #(
    parameter int SAMPLE_DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input words
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] now_ms, [63:32] add_bytes, [95:64] add_actual
    input  logic [wtrm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] kind
    input  logic [wtrm_pkg::KIND_W-1:0]      s_axis_tuser,
    // result words
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [47:0] position, [95:48] actual_bytes, [143:96] speed_bps,
    // [191:144] seconds_left
    output logic [wtrm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [wtrm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wtrm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int HW = $clog2(SAMPLE_DEPTH);         // ring slot index
    localparam int CW = $clog2(SAMPLE_DEPTH + 1);     // ring fill count
    localparam int MW = (CW > wtrm_pkg::MSMP_W) ? CW : wtrm_pkg::MSMP_W;
    localparam int PW = wtrm_pkg::POS_W;
    localparam int TW = wtrm_pkg::TIME_W;
    localparam int DW = wtrm_pkg::DIV_DW;
    localparam int VW = wtrm_pkg::DIV_VW;

    // slot = (base + off) mod depth, with base + off below twice the depth
    function automatic logic [HW-1:0] wrap_add(input logic [HW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [HW:0] s;
        s = (HW+1)'(base) + (HW+1)'(off);
        if (s >= (HW+1)'(SAMPLE_DEPTH)) begin
            s = s - (HW+1)'(SAMPLE_DEPTH);
        end
        return s[HW-1:0];
    endfunction

    // ---- registers ----
    wtrm_pkg::t_state r_state, n_state;

    logic [PW-1:0]                  r_seg_size,  n_seg_size;
    logic [PW-1:0]                  r_file_size, n_file_size;
    logic                           r_whole,     n_whole;
    logic [wtrm_pkg::MWIN_W-1:0]    r_min_win,   n_min_win;
    logic [wtrm_pkg::MSMP_W-1:0]    r_min_smp,   n_min_smp;

    logic [HW-1:0] r_head,  n_head;   // oldest sample
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] r_pos,   n_pos;
    logic [PW-1:0] r_act,   n_act;
    logic [PW-1:0] r_speed, n_speed;  // cached, changes only on tick or clear
    logic [PW-1:0] r_left,  n_left;

    logic [TW-1:0] r_now,    n_now;
    logic [TW-1:0] r_thr,    n_thr;    // (min_window_secs + 1) * 1000
    logic [TW-1:0] r_t_old,  n_t_old;
    logic [PW-1:0] r_p_old,  n_p_old;
    logic [TW-1:0] r_ticks,  n_ticks;
    logic [PW-1:0] r_bytes,  n_bytes;

    logic                                r_out_valid, n_out_valid;
    logic [wtrm_pkg::OUT_DATA_W-1:0]     r_out_data,  n_out_data;

    // ---- sample ring memories ----
    logic [HW-1:0] ram_raddr;
    logic [HW-1:0] ram_waddr;
    logic          time_we;
    logic          pos_we;
    logic [TW-1:0] rd_time;
    logic [PW-1:0] rd_pos;

    // ---- divider ----
    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic [VW-1:0] div_divisor;
    logic          div_busy;
    logic [DW-1:0] div_q;

    // ---- helpers ----
    logic [HW-1:0] last_slot;
    logic [MW-1:0] cnt_ext;
    logic [MW-1:0] msmp_ext;   // minimum sample count with zero read as one
    logic [TW-1:0] mwin_p1;
    logic [TW-1:0] thr_w;
    logic [TW-1:0] span;
    logic [TW-1:0] ticks_w;
    logic [DW-1:0] bytes_ext;
    logic [DW-1:0] bytes_x1000;
    logic [PW-1:0] size_sel;
    logic [PW-1:0] speed_sat;

    assign last_slot = wrap_add(r_head, r_count - CW'(1));
    assign cnt_ext   = MW'(r_count);
    assign msmp_ext  = (r_min_smp == '0) ? MW'(1) : MW'(r_min_smp);
    assign mwin_p1   = TW'(r_min_win) + TW'(1);
    assign thr_w     = (mwin_p1 << 10) - (mwin_p1 << 4) - (mwin_p1 << 3);
    assign span      = rd_time - r_t_old;
    assign ticks_w   = rd_time - r_t_old;
    assign bytes_ext = DW'(r_bytes);
    assign bytes_x1000 = (bytes_ext << 10) - (bytes_ext << 4) - (bytes_ext << 3);
    assign size_sel  = r_whole ? r_file_size : r_seg_size;
    assign speed_sat = (|div_q[DW-1:PW]) ? {PW{1'b1}} : div_q[PW-1:0];

    always_comb begin
        n_state     = r_state;
        n_seg_size  = r_seg_size;
        n_file_size = r_file_size;
        n_whole     = r_whole;
        n_min_win   = r_min_win;
        n_min_smp   = r_min_smp;
        n_head      = r_head;
        n_count     = r_count;
        n_pos       = r_pos;
        n_act       = r_act;
        n_speed     = r_speed;
        n_left      = r_left;
        n_now       = r_now;
        n_thr       = r_thr;
        n_t_old     = r_t_old;
        n_p_old     = r_p_old;
        n_ticks     = r_ticks;
        n_bytes     = r_bytes;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        ram_raddr    = r_head;
        ram_waddr    = last_slot;
        time_we      = 1'b0;
        pos_we       = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;

        // config writes: the user must send them only while the block is idle; the block itself does not enforce it
        if (i_cfg_valid) begin
            case (i_cfg_index)
                wtrm_pkg::REG_SEGMENT_SIZE:    n_seg_size  = i_cfg_data;
                wtrm_pkg::REG_FILE_SIZE:       n_file_size = i_cfg_data;
                wtrm_pkg::REG_WHOLE_FILE:      n_whole     = i_cfg_data[0];
                wtrm_pkg::REG_MIN_WINDOW_SECS: n_min_win   = i_cfg_data[wtrm_pkg::MWIN_W-1:0];
                wtrm_pkg::REG_MIN_SAMPLES:     n_min_smp   = i_cfg_data[wtrm_pkg::MSMP_W-1:0];
                default: ;
            endcase
        end

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            wtrm_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_now = s_axis_tdata[31:0];
                    case (s_axis_tuser)
                        wtrm_pkg::KIND_PROGRESS: begin
                            n_pos   = r_pos + PW'(s_axis_tdata[63:32]);
                            n_act   = r_act + PW'(s_axis_tdata[95:64]);
                            n_state = wtrm_pkg::ST_L_START;
                        end
                        wtrm_pkg::KIND_TICK: begin
                            n_thr   = thr_w;
                            n_state = wtrm_pkg::ST_T_RD_OLD;
                        end
                        wtrm_pkg::KIND_CLEAR: begin
                            n_pos   = '0;
                            n_act   = '0;
                            n_head  = '0;
                            n_count = '0;
                            n_speed = '0;
                            n_state = wtrm_pkg::ST_L_START;
                        end
                        default: n_state = wtrm_pkg::ST_L_START;
                    endcase
                end
            end
            // tick: read oldest and newest time for the window test
            wtrm_pkg::ST_T_RD_OLD: begin
                ram_raddr = r_head;
                n_state   = wtrm_pkg::ST_T_RD_NEW;
            end
            wtrm_pkg::ST_T_RD_NEW: begin
                ram_raddr = last_slot;
                n_t_old   = rd_time;
                n_state   = wtrm_pkg::ST_T_TRIM;
            end
            wtrm_pkg::ST_T_TRIM: begin
                // window too long: keep one fewer than the minimum count, in one step
                if (span >= r_thr && cnt_ext >= msmp_ext) begin
                    n_count = CW'(msmp_ext - MW'(1));
                    n_head  = wrap_add(r_head, r_count - CW'(msmp_ext - MW'(1)));
                end
                n_state = wtrm_pkg::ST_T_CHK;
            end
            wtrm_pkg::ST_T_CHK: begin
                ram_raddr = last_slot;
                n_state   = (r_count > CW'(1)) ? wtrm_pkg::ST_T_SAME
                                               : wtrm_pkg::ST_T_APPEND;
            end
            wtrm_pkg::ST_T_SAME: begin
                // no movement: refresh newest time only
                if (rd_pos == r_pos) begin
                    time_we   = 1'b1;
                    ram_waddr = last_slot;
                    n_state   = wtrm_pkg::ST_S_RD_OLD;
                end else begin
                    n_state   = wtrm_pkg::ST_T_APPEND;
                end
            end
            wtrm_pkg::ST_T_APPEND: begin
                time_we = 1'b1;
                pos_we  = 1'b1;
                if (r_count == CW'(SAMPLE_DEPTH)) begin
                    // full: overwrite the oldest and advance
                    ram_waddr = r_head;
                    n_head    = wrap_add(r_head, CW'(1));
                end else begin
                    ram_waddr = wrap_add(r_head, r_count);
                    n_count   = r_count + CW'(1);
                end
                n_state = wtrm_pkg::ST_S_RD_OLD;
            end
            // speed over the ring
            wtrm_pkg::ST_S_RD_OLD: begin
                ram_raddr = r_head;
                if (r_count < CW'(2)) begin
                    n_speed = '0;
                    n_state = wtrm_pkg::ST_L_START;
                end else begin
                    n_state = wtrm_pkg::ST_S_RD_NEW;
                end
            end
            wtrm_pkg::ST_S_RD_NEW: begin
                ram_raddr = last_slot;
                n_t_old   = rd_time;
                n_p_old   = rd_pos;
                n_state   = wtrm_pkg::ST_S_DIFF;
            end
            wtrm_pkg::ST_S_DIFF: begin
                n_ticks = ticks_w;
                n_bytes = rd_pos - r_p_old;
                if (ticks_w == '0) begin
                    n_speed = '0;
                    n_state = wtrm_pkg::ST_L_START;
                end else begin
                    n_state = wtrm_pkg::ST_S_START;
                end
            end
            wtrm_pkg::ST_S_START: begin
                div_start    = 1'b1;
                div_dividend = bytes_x1000;
                div_divisor  = VW'(r_ticks);
                n_state      = wtrm_pkg::ST_S_DIV;
            end
            wtrm_pkg::ST_S_DIV: begin
                if (!div_busy) begin
                    n_speed = speed_sat;
                    n_state = wtrm_pkg::ST_L_START;
                end
            end
            // seconds left
            wtrm_pkg::ST_L_START: begin
                if (r_speed != '0 && size_sel >= r_pos) begin
                    div_start    = 1'b1;
                    div_dividend = DW'(size_sel - r_pos);
                    div_divisor  = r_speed;
                    n_state      = wtrm_pkg::ST_L_DIV;
                end else begin
                    n_left  = '0;
                    n_state = wtrm_pkg::ST_OUT;
                end
            end
            wtrm_pkg::ST_L_DIV: begin
                if (!div_busy) begin
                    n_left  = div_q[PW-1:0];
                    n_state = wtrm_pkg::ST_OUT;
                end
            end
            wtrm_pkg::ST_OUT: begin
                // wait for the result register to free up
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_left, r_speed, r_act, r_pos};
                    n_state     = wtrm_pkg::ST_IDLE;
                end
            end
            default: n_state = wtrm_pkg::ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wtrm_pkg::ST_IDLE;
            r_seg_size  <= '0;
            r_file_size <= '0;
            r_whole     <= 1'b0;
            r_min_win   <= wtrm_pkg::RST_MIN_WINDOW_SECS;
            r_min_smp   <= wtrm_pkg::RST_MIN_SAMPLES;
            r_head      <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_act       <= '0;
            r_speed     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seg_size  <= n_seg_size;
            r_file_size <= n_file_size;
            r_whole     <= n_whole;
            r_min_win   <= n_min_win;
            r_min_smp   <= n_min_smp;
            r_head      <= n_head;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_act       <= n_act;
            r_speed     <= n_speed;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_left     <= n_left;
        r_now      <= n_now;
        r_thr      <= n_thr;
        r_t_old    <= n_t_old;
        r_p_old    <= n_p_old;
        r_ticks    <= n_ticks;
        r_bytes    <= n_bytes;
        r_out_data <= n_out_data;
    end

    wtrm_ram #(.WIDTH(TW), .DEPTH(SAMPLE_DEPTH)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (time_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_now),
        .i_raddr (ram_raddr),
        .o_rdata (rd_time)
    );

    wtrm_ram #(.WIDTH(PW), .DEPTH(SAMPLE_DEPTH)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_pos),
        .i_raddr (ram_raddr),
        .o_rdata (rd_pos)
    );

    wtrm_div #(.DW(DW), .VW(VW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    assign s_axis_tready = (r_state == wtrm_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_cfg_ready   = 1'b1;

endmodule

/* hw/rtl/wtrm_chk.sv */
// ----------------------------------------------------------------------------
// wtrm_chk: port-level checks for the rate meter
// Tracks words in flight and checks result holding, the in-flight limit and zeroing.
// ----------------------------------------------------------------------------
module wtrm_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [wtrm_pkg::KIND_W-1:0]     s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [wtrm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic       s_acc;
    logic       m_acc;
    logic [1:0] r_outst;     // words accepted, result not yet taken
    logic       r_last_clr;  // newest accepted word was a clear

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst    <= '0;
            r_last_clr <= 1'b0;
        end else begin
            r_outst <= r_outst + 2'(s_acc) - 2'(m_acc);
            if (s_acc) begin
                r_last_clr <= (s_axis_tuser == wtrm_pkg::KIND_CLEAR);
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |-> r_outst < 2'd2)
        else $error("word accepted with two results outstanding");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_outst != 2'd0)
        else $error("result word without an accepted input");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_acc && r_outst == 2'd1 && r_last_clr |->
            m_axis_tdata[47:0] == '0 && m_axis_tdata[95:48] == '0 &&
            m_axis_tdata[143:96] == '0 && m_axis_tdata[191:144] == '0)
        else $error("clear word did not give an all-zero result");

    a_left_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[143:96] == '0 |-> m_axis_tdata[191:144] == '0)
        else $error("seconds left non-zero at zero speed");

endmodule

bind windowed_transfer_rate_meter wtrm_chk u_wtrm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
